/* rtl/pcpe_pkg.sv */
// ----------------------------------------------------------------------------
// pcpe_pkg
// Shared types and constants of the picture column post encoder: defaults,
// register indexes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pcpe_pkg;

    // parameter defaults
    localparam int DEF_MAX_COLUMN_HEIGHT = 1024;
    localparam int DEF_MAX_POST_LEN      = 240;

    // field widths
    localparam int PIXEL_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CHUNK_W     = 64;
    localparam int BCOUNT_W    = 4;
    localparam int OFFSET_W    = 32;

    // post format
    localparam int             LAST_VISIBLE_START = 252;
    localparam logic [7:0]     END_MARKER         = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_EN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_INDEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic                  RST_TRANSP_EN     = 1'b0;
    localparam logic [PIXEL_W-1:0]    RST_TRANSP_INDEX  = 8'd255;
    localparam logic [CFG_DATA_W-1:0] RST_COLUMN_HEIGHT = 11'd128;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_LEN,
        ST_FIRST,
        ST_PIX,
        ST_LASTPAD,
        ST_MARK
    } state_t;

    // which byte the datapath hands to the chunk packer
    typedef enum logic [2:0] {
        SEL_ROW,
        SEL_LEN,
        SEL_FIRST,
        SEL_PIX,
        SEL_LASTPAD,
        SEL_MARK
    } byte_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic      take;   // input channel open
        logic      push;   // move one byte into the packer
        logic      last;   // final byte of this pixel's output
        byte_sel_t sel;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic accept;      // pixel beat taken this cycle
        logic emit_post;   // accepted pixel closes a visible post
        logic col_end;     // accepted pixel ends its column
        logic col_end_reg; // latched column end of the step in flight
        logic pix_last;    // current run-store byte is the final one
        logic push_ok;     // packer can take a byte this cycle
    } dp_status_t;

endpackage

/* rtl/pcpe_ram.sv */
// ----------------------------------------------------------------------------
// pcpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 240
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/pcpe_ctrl.sv */
// ----------------------------------------------------------------------------
// pcpe_ctrl
// Sequencer of the post encoder: takes a pixel in idle, then walks the bytes
// of the post and the end marker to the packer, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pcpe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcpe_pkg::dp_status_t  status,
    output pcpe_pkg::ctrl_cmd_t   cmd
);
    import pcpe_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (status.accept && status.emit_post) begin
                    state_next = ST_ROW;
                end else if (status.accept && status.col_end) begin
                    state_next = ST_MARK;
                end
            end
            ST_ROW: begin
                if (status.push_ok) state_next = ST_LEN;
            end
            ST_LEN: begin
                if (status.push_ok) state_next = ST_FIRST;
            end
            ST_FIRST: begin
                if (status.push_ok) state_next = ST_PIX;
            end
            ST_PIX: begin
                if (status.push_ok && status.pix_last) state_next = ST_LASTPAD;
            end
            ST_LASTPAD: begin
                if (status.push_ok) begin
                    state_next = status.col_end_reg ? ST_MARK : ST_IDLE;
                end
            end
            ST_MARK: begin
                if (status.push_ok) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs; last follows state and col_end_reg, push follows packer space
    always_comb begin
        cmd.take = 1'b0;
        cmd.push = 1'b0;
        cmd.last = 1'b0;
        cmd.sel  = SEL_ROW;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = 1'b1;
            end
            ST_ROW: begin
                cmd.push = status.push_ok;
                cmd.sel  = SEL_ROW;
            end
            ST_LEN: begin
                cmd.push = status.push_ok;
                cmd.sel  = SEL_LEN;
            end
            ST_FIRST: begin
                cmd.push = status.push_ok;
                cmd.sel  = SEL_FIRST;
            end
            ST_PIX: begin
                cmd.push = status.push_ok;
                cmd.sel  = SEL_PIX;
            end
            ST_LASTPAD: begin
                cmd.push = status.push_ok;
                cmd.last = !status.col_end_reg;
                cmd.sel  = SEL_LASTPAD;
            end
            ST_MARK: begin
                cmd.push = status.push_ok;
                cmd.last = 1'b1;
                cmd.sel  = SEL_MARK;
            end
            default: begin
                cmd.take = 1'b0;
            end
        endcase
    end

    // a stalled run-store byte keeps the sequencer on it
    a_pix_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PIX && !cmd.push) |=> (state_reg == ST_PIX))
        else $error("pcpe_ctrl: left pixel readout without a push");

endmodule

/* rtl/pcpe_datapath.sv */
// ----------------------------------------------------------------------------
// pcpe_datapath
// Configuration registers, run state, run store, byte selection, chunk
// packer and output register of the post encoder.
// ----------------------------------------------------------------------------
module pcpe_datapath #(
    parameter int MAX_COLUMN_HEIGHT = pcpe_pkg::DEF_MAX_COLUMN_HEIGHT,
    parameter int MAX_POST_LEN      = pcpe_pkg::DEF_MAX_POST_LEN
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcpe_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixels
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pcpe_pkg::PIXEL_W-1:0]      s_pixel,
    // chunks
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pcpe_pkg::CHUNK_W-1:0]      m_chunk_bytes,
    output logic [pcpe_pkg::BCOUNT_W-1:0]     m_byte_count,
    output logic                              m_last_of_run,
    output logic                              m_column_end,
    output logic [pcpe_pkg::OFFSET_W-1:0]     m_column_offset,
    // controller
    input  pcpe_pkg::ctrl_cmd_t               cmd,
    output pcpe_pkg::dp_status_t              status
);
    import pcpe_pkg::*;

    localparam int ROW_W  = (MAX_COLUMN_HEIGHT > 1) ? $clog2(MAX_COLUMN_HEIGHT) : 1;
    localparam int ROWP_W = ROW_W + 1;
    localparam int H_W    = $clog2(MAX_COLUMN_HEIGHT + 1);
    localparam int LEN_W  = $clog2(MAX_POST_LEN + 1);
    localparam int ADDR_W = (MAX_POST_LEN > 1) ? $clog2(MAX_POST_LEN) : 1;

    // configuration
    logic                  tr_en_reg;
    logic [PIXEL_W-1:0]    tr_idx_reg;
    logic [CFG_DATA_W-1:0] col_h_reg;

    // run state
    logic [LEN_W-1:0]      run_len_reg,  run_len_next;
    logic [ROW_W-1:0]      start_reg,    start_next;
    logic [ROW_W-1:0]      row_reg,      row_next;
    logic [OFFSET_W-1:0]   total_reg,    total_next;
    logic [OFFSET_W-1:0]   col_base_reg, col_base_next;

    // latched step for readout (payload)
    logic [LEN_W-1:0]      post_len_reg;
    logic [ROW_W-1:0]      post_row_reg;
    logic                  col_end_reg;
    logic [PIXEL_W-1:0]    first_pix_reg;
    logic [PIXEL_W-1:0]    last_pix_reg;
    logic [ADDR_W-1:0]     idx_reg;

    // packer and output register
    logic [CHUNK_W-1:0]    acc_reg,     acc_next;
    logic [2:0]            acc_cnt_reg, acc_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHUNK_W-1:0]    m_data_reg;
    logic [BCOUNT_W-1:0]   m_cnt_reg;
    logic                  m_last_reg;
    logic                  m_cend_reg;
    logic [OFFSET_W-1:0]   m_off_reg;

    logic                  accept;
    logic [H_W-1:0]        h_eff;
    logic [ROWP_W-1:0]     row_plus;
    logic                  col_end_now;
    logic                  is_trans;
    logic [LEN_W-1:0]      len_inc;
    logic [LEN_W-1:0]      len_new;
    logic [ROW_W-1:0]      start_new;
    logic                  full;
    logic                  closing;
    logic                  emit_post;
    logic [LEN_W-1:0]      idx_plus;
    logic                  pix_last;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [PIXEL_W-1:0]    ram_rdata;
    logic [PIXEL_W-1:0]    byte_sel;
    logic                  out_free;
    logic                  chunk_done;
    logic [CHUNK_W-1:0]    acc_ins;

    assign cfg_ready = 1'b1;
    assign s_ready   = cmd.take;
    assign accept    = s_valid && cmd.take;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tr_en_reg  <= RST_TRANSP_EN;
            tr_idx_reg <= RST_TRANSP_INDEX;
            col_h_reg  <= RST_COLUMN_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TRANSP_EN:     tr_en_reg  <= cfg_data[0];
                CFG_TRANSP_INDEX:  tr_idx_reg <= cfg_data[PIXEL_W-1:0];
                CFG_COLUMN_HEIGHT: col_h_reg  <= cfg_data;
                default:           tr_en_reg  <= tr_en_reg;
            endcase
        end
    end

    // effective height: zero reads as one, large values saturate
    always_comb begin
        if (col_h_reg == '0) begin
            h_eff = H_W'(1);
        end else if (32'(col_h_reg) > 32'(MAX_COLUMN_HEIGHT)) begin
            h_eff = H_W'(MAX_COLUMN_HEIGHT);
        end else begin
            h_eff = H_W'(col_h_reg);
        end
    end

    // step decode for the pixel on the input
    always_comb begin
        row_plus    = ROWP_W'(row_reg) + ROWP_W'(1);
        col_end_now = 32'(row_plus) >= 32'(h_eff);
        is_trans    = tr_en_reg && (s_pixel == tr_idx_reg);
        len_inc     = run_len_reg + LEN_W'(1);
        len_new     = is_trans ? run_len_reg : len_inc;
        start_new   = (!is_trans && run_len_reg == '0) ? row_reg : start_reg;
        full        = !is_trans && (32'(len_inc) >= 32'(MAX_POST_LEN));
        closing     = is_trans || full || col_end_now;
        emit_post   = closing && (len_new != '0)
                      && (32'(start_new) <= 32'(LAST_VISIBLE_START));
    end

    // run state update on accept
    always_comb begin
        run_len_next = run_len_reg;
        start_next   = start_reg;
        row_next     = row_reg;
        if (accept) begin
            run_len_next = closing ? '0 : len_new;
            start_next   = start_new;
            row_next     = col_end_now ? '0 : row_plus[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            start_reg   <= '0;
            row_reg     <= '0;
        end else begin
            run_len_reg <= run_len_next;
            start_reg   <= start_next;
            row_reg     <= row_next;
        end
    end

    // step latch for the readout
    always_ff @(posedge aclk) begin
        if (accept) begin
            post_len_reg <= len_new;
            post_row_reg <= start_new;
            col_end_reg  <= col_end_now;
            if (!is_trans) begin
                last_pix_reg <= s_pixel;
                if (run_len_reg == '0) first_pix_reg <= s_pixel;
            end
        end
    end

    // run store readout: rdata holds the byte at idx while in pixel phase
    always_comb begin
        idx_plus  = LEN_W'(idx_reg) + LEN_W'(1);
        pix_last  = (idx_plus == post_len_reg);
        ram_re    = cmd.push && ((cmd.sel == SEL_FIRST)
                                 || (cmd.sel == SEL_PIX && !pix_last));
        ram_raddr = (cmd.sel == SEL_FIRST) ? '0 : idx_plus[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && cmd.sel == SEL_FIRST) begin
            idx_reg <= '0;
        end else if (cmd.push && cmd.sel == SEL_PIX) begin
            idx_reg <= idx_plus[ADDR_W-1:0];
        end
    end

    pcpe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_POST_LEN)
    ) u_run_store (
        .aclk  (aclk),
        .we    (accept && !is_trans),
        .waddr (run_len_reg[ADDR_W-1:0]),
        .wdata (s_pixel),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // byte select
    always_comb begin
        unique case (cmd.sel)
            SEL_ROW:     byte_sel = 8'(post_row_reg);
            SEL_LEN:     byte_sel = 8'(post_len_reg);
            SEL_FIRST:   byte_sel = first_pix_reg;
            SEL_PIX:     byte_sel = ram_rdata;
            SEL_LASTPAD: byte_sel = last_pix_reg;
            SEL_MARK:    byte_sel = END_MARKER;
            default:     byte_sel = END_MARKER;
        endcase
    end

    // chunk packer: a byte that fills or ends a chunk needs the output slot
    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        chunk_done   = cmd.push && ((acc_cnt_reg == 3'd7) || cmd.last);
        acc_ins      = acc_reg | (CHUNK_W'(byte_sel) << {acc_cnt_reg, 3'b000});
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        if (cmd.push) begin
            acc_next     = chunk_done ? '0 : acc_ins;
            acc_cnt_next = chunk_done ? 3'd0 : acc_cnt_reg + 3'd1;
        end
    end

    // byte counter and column base
    always_comb begin
        total_next    = total_reg;
        col_base_next = col_base_reg;
        if (cmd.push) begin
            total_next = total_reg + OFFSET_W'(1);
            if (cmd.last && col_end_reg) col_base_next = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            acc_cnt_reg  <= '0;
            total_reg    <= '0;
            col_base_reg <= '0;
        end else begin
            acc_reg      <= acc_next;
            acc_cnt_reg  <= acc_cnt_next;
            total_reg    <= total_next;
            col_base_reg <= col_base_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (chunk_done) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (chunk_done) begin
            m_data_reg <= acc_ins;
            m_cnt_reg  <= BCOUNT_W'(acc_cnt_reg) + BCOUNT_W'(1);
            m_last_reg <= cmd.last;
            m_cend_reg <= cmd.last && col_end_reg;
            m_off_reg  <= col_base_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chunk_bytes   = m_data_reg;
    assign m_byte_count    = m_cnt_reg;
    assign m_last_of_run   = m_last_reg;
    assign m_column_end    = m_cend_reg;
    assign m_column_offset = m_off_reg;

    // status to controller
    always_comb begin
        status.accept      = accept;
        status.emit_post   = emit_post;
        status.col_end     = col_end_now;
        status.col_end_reg = col_end_reg;
        status.pix_last    = pix_last;
        status.push_ok     = !((acc_cnt_reg == 3'd7) || cmd.last) || out_free;
    end

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> status.push_ok)
        else $error("pcpe_datapath: byte pushed with no room for its chunk");

    a_packer_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && cmd.last) |=> (acc_cnt_reg == 3'd0))
        else $error("pcpe_datapath: packer not empty after final byte");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (32'(run_len_reg) < 32'(MAX_POST_LEN)))
        else $error("pcpe_datapath: open run reached the post limit");

endmodule

/* rtl/picture_column_post_encoder.sv */
// ----------------------------------------------------------------------------
// picture_column_post_encoder
// Turns a column-major pixel stream into posts and end markers, packed into
// chunks of up to eight bytes tagged with the column's byte offset.
// ----------------------------------------------------------------------------
// A pixel beat that closes no post and ends no column leaves the block ready
// for the next beat. One that ends a column with no visible post emits only
// the end marker. One that closes a visible post of n pixels emits its row,
// length, first pixel, n pixels, last pixel and, if it ends the column, the
// end marker: every output byte passes the chunk packer one per cycle, and
// run pixels come from the single byte-wide read port of the run store. A
// chunk waiting in the output register stalls the packer only on the byte
// that would complete the next chunk. Configuration, on its own always-ready
// channel, must be written only between pixel steps, which is not enforced.
module picture_column_post_encoder #(
    parameter int MAX_COLUMN_HEIGHT = pcpe_pkg::DEF_MAX_COLUMN_HEIGHT,
    parameter int MAX_POST_LEN      = pcpe_pkg::DEF_MAX_POST_LEN
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcpe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pcpe_pkg::PIXEL_W-1:0]      s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pcpe_pkg::CHUNK_W-1:0]      m_chunk_bytes,
    output logic [pcpe_pkg::BCOUNT_W-1:0]     m_byte_count,
    output logic                              m_last_of_run,
    output logic                              m_column_end,
    output logic [pcpe_pkg::OFFSET_W-1:0]     m_column_offset
);
    import pcpe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    pcpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    pcpe_datapath #(
        .MAX_COLUMN_HEIGHT (MAX_COLUMN_HEIGHT),
        .MAX_POST_LEN      (MAX_POST_LEN)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chunk_bytes   (m_chunk_bytes),
        .m_byte_count    (m_byte_count),
        .m_last_of_run   (m_last_of_run),
        .m_column_end    (m_column_end),
        .m_column_offset (m_column_offset),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

/* test/tb_picture_column_post_encoder.sv */
// ----------------------------------------------------------------------------
// tb_picture_column_post_encoder
// Self-checking bench for the column post encoder. A table of directed pixel
// and register beats runs first, then random phases: short columns with mixed
// transparency, one tall column that fills a whole run and drops late posts,
// and a closing stretch with no idling. Every output beat is compared field
// by field with hand-typed chunks or those of an in-bench encoder model.
// ----------------------------------------------------------------------------
module tb_picture_column_post_encoder;
    import pcpe_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 300;
    localparam int POST_CAP      = DEF_MAX_POST_LEN;
    localparam int HEIGHT_CAP    = DEF_MAX_COLUMN_HEIGHT;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef struct packed {
        logic [CHUNK_W-1:0]  data;
        logic [BCOUNT_W-1:0] count;
        logic                last;
        logic                col_end;
        logic [OFFSET_W-1:0] offset;
    } chunk_t;

    typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [PIXEL_W-1:0]     pix;
        bit                     known;
        chunk_t                 want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic [CHUNK_W-1:0]     m_chunk_bytes;
    logic [BCOUNT_W-1:0]    m_byte_count;
    logic                   m_last_of_run;
    logic                   m_column_end;
    logic [OFFSET_W-1:0]    m_column_offset;

    picture_column_post_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chunk_bytes   (m_chunk_bytes),
        .m_byte_count    (m_byte_count),
        .m_last_of_run   (m_last_of_run),
        .m_column_end    (m_column_end),
        .m_column_offset (m_column_offset)
    );

    // encoder model: configuration and column state
    bit                     cfg_transp_en  = RST_TRANSP_EN;
    logic [PIXEL_W-1:0]     cfg_transp_idx = RST_TRANSP_INDEX;
    logic [CFG_DATA_W-1:0]  cfg_height     = RST_COLUMN_HEIGHT;
    logic [7:0]             run_pixels [POST_CAP];
    int                     run_len    = 0;
    logic [9:0]             run_row    = '0;
    logic [9:0]             row_now    = '0;
    logic [OFFSET_W-1:0]    bytes_out  = '0;
    logic [OFFSET_W-1:0]    col_base   = '0;
    logic [7:0]             step_bytes[$];
    chunk_t                 step_chunks[$];

    chunk_t                 pending_chunks[$];
    stim_row_t              stim_table[$];
    int                     fails      = 0;
    int                     items_sent = 0;
    int                     cycles     = 0;
    bit                     idle_on    = 1'b0;
    bit                     quiet      = 1'b0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_picture_column_post_encoder failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------------

    // close the open run; a post starting below the last visible row is lost
    function automatic void flush_post();
        if (run_len == 0) return;
        if (run_row <= LAST_VISIBLE_START) begin
            step_bytes.push_back(8'(run_row));
            step_bytes.push_back(8'(run_len));
            step_bytes.push_back(run_pixels[0]);
            for (int i = 0; i < run_len; i++) step_bytes.push_back(run_pixels[i]);
            step_bytes.push_back(run_pixels[run_len-1]);
        end
        run_len = 0;
    endfunction

    // one pixel in, the chunks it causes into step_chunks
    function automatic void encode_pixel(input logic [PIXEL_W-1:0] pix);
        int                  eff_h;
        int                  n;
        int                  cnt;
        bit                  col_done;
        logic [OFFSET_W-1:0] base;
        chunk_t              c;
        eff_h = int'(cfg_height);
        if (eff_h < 1) eff_h = 1;
        if (eff_h > HEIGHT_CAP) eff_h = HEIGHT_CAP;
        base = col_base;
        step_bytes.delete();
        step_chunks.delete();

        if (cfg_transp_en && pix == cfg_transp_idx) begin
            flush_post();
        end else begin
            if (run_len == 0) run_row = row_now;
            if (run_len < POST_CAP) begin
                run_pixels[run_len] = pix;
                run_len++;
            end
            if (run_len >= POST_CAP) flush_post();
        end

        col_done = (int'(row_now) + 1 >= eff_h);
        if (col_done) begin
            flush_post();
            step_bytes.push_back(END_MARKER);
            row_now = '0;
        end else begin
            row_now = row_now + 10'd1;
        end

        // pack, first byte lowest
        n = step_bytes.size();
        for (int pos = 0; pos < n; pos += 8) begin
            cnt = (n - pos > 8) ? 8 : n - pos;
            c = '0;
            for (int k = 0; k < cnt; k++) c.data[8*k +: 8] = step_bytes[pos+k];
            c.count   = BCOUNT_W'(cnt);
            c.last    = (pos + cnt >= n);
            c.col_end = c.last && col_done;
            c.offset  = base;
            step_chunks.push_back(c);
        end
        bytes_out = bytes_out + OFFSET_W'(n);
        if (col_done) col_base = bytes_out;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TRANSP_EN:     cfg_transp_en  = val[0];
            CFG_TRANSP_INDEX:  cfg_transp_idx = val[PIXEL_W-1:0];
            CFG_COLUMN_HEIGHT: cfg_height     = val;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one pixel beat, with an optional idle burst in front
    task automatic feed_pixel(input logic [PIXEL_W-1:0] pix, input bit known,
                              input chunk_t want);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_pixel(pix);
        if (known) begin
            pending_chunks.push_back(want);
        end else begin
            foreach (step_chunks[i]) pending_chunks.push_back(step_chunks[i]);
        end
        items_sent++;
    endtask

    // stop feeding and let every expected beat come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // short columns, random settings
    task automatic random_phase(input int n_items);
        logic [PIXEL_W-1:0]    tidx;
        logic [CFG_DATA_W-1:0] height;
        logic [PIXEL_W-1:0]    pix;
        drain();
        idle_on = !quiet && ($urandom_range(0, 3) != 0);
        write_reg(CFG_TRANSP_EN, CFG_DATA_W'($urandom_range(0, 2047)));
        case ($urandom_range(0, 3))
            0:       tidx = 8'h00;
            1:       tidx = 8'hFF;
            default: tidx = 8'($urandom_range(0, 255));
        endcase
        write_reg(CFG_TRANSP_INDEX, {3'($urandom_range(0, 7)), tidx});
        if ($urandom_range(0, 7) == 0) height = CFG_DATA_W'($urandom_range(21, 2047));
        else height = CFG_DATA_W'($urandom_range(0, 20));
        write_reg(CFG_COLUMN_HEIGHT, height);
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_NO_REG, CFG_DATA_W'($urandom_range(0, 2047)));
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 2) == 0) pix = tidx;
            else pix = 8'($urandom_range(0, 255));
            feed_pixel(pix, 1'b0, '0);
        end
    endtask

    // one tall column: a full run, then posts starting past the last
    // visible row; left open so the next phase lowers the height mid-column
    task automatic tall_column();
        logic [PIXEL_W-1:0] tidx;
        logic [PIXEL_W-1:0] pix;
        drain();
        write_reg(CFG_COLUMN_HEIGHT, 11'd1);
        feed_pixel(8'($urandom_range(0, 255)), 1'b0, '0);
        drain();
        tidx = 8'($urandom_range(0, 255));
        write_reg(CFG_TRANSP_EN, 11'd1);
        write_reg(CFG_TRANSP_INDEX, {3'b000, tidx});
        write_reg(CFG_COLUMN_HEIGHT, CFG_DATA_W'($urandom_range(1024, 2047)));
        for (int k = 0; k < 250; k++)
            feed_pixel(tidx + 8'($urandom_range(1, 255)), 1'b0, '0);
        for (int k = 250; k < 262; k++) begin
            if ($urandom_range(0, 1) == 0) pix = tidx;
            else pix = 8'($urandom_range(0, 255));
            feed_pixel(pix, 1'b0, '0);
        end
    endtask

    // directed table rows
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{kind: ROW_REG, reg_idx: idx, reg_val: val, pix: '0, known: 1'b0, want: '0};
        stim_table.push_back(r);
    endfunction

    function automatic void add_pix(input logic [PIXEL_W-1:0] pix);
        stim_row_t r;
        r = '{kind: ROW_PIX, reg_idx: '0, reg_val: '0, pix: pix, known: 1'b0, want: '0};
        stim_table.push_back(r);
    endfunction

    // pixel whose output is a single chunk typed in by hand
    function automatic void add_known(input logic [PIXEL_W-1:0] pix,
                                      input logic [CHUNK_W-1:0] data,
                                      input int cnt, input bit col_end,
                                      input logic [OFFSET_W-1:0] offset);
        stim_row_t r;
        chunk_t    c;
        c = '{data: data, count: BCOUNT_W'(cnt), last: 1'b1, col_end: col_end,
              offset: offset};
        r = '{kind: ROW_PIX, reg_idx: '0, reg_val: '0, pix: pix, known: 1'b1, want: c};
        stim_table.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_pixel   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // height zero acts as one: every pixel is a whole column
        add_reg(CFG_COLUMN_HEIGHT, 11'd0);
        add_known(8'h00, 64'h0000_FF00_0000_0100, 6, 1'b1, 32'd0);
        add_known(8'hFF, 64'h0000_FFFF_FFFF_0100, 6, 1'b1, 32'd6);
        // transparent pixel: only the end marker
        add_reg(CFG_TRANSP_EN, 11'd1);
        add_known(8'hFF, 64'h0000_0000_0000_00FF, 1, 1'b1, 32'd12);
        add_known(8'h7E, 64'h0000_FF7E_7E7E_0100, 6, 1'b1, 32'd13);
        add_reg(CFG_TRANSP_INDEX, 11'd0);
        add_known(8'h00, 64'h0000_0000_0000_00FF, 1, 1'b1, 32'd19);
        add_known(8'hFF, 64'h0000_FFFF_FFFF_0100, 6, 1'b1, 32'd20);
        // write to a missing register changes nothing
        add_reg(CFG_NO_REG, 11'd2047);
        add_known(8'h00, 64'h0000_0000_0000_00FF, 1, 1'b1, 32'd26);
        // three-row column: silent pixel, post closed mid-column, last row
        add_reg(CFG_COLUMN_HEIGHT, 11'd3);
        add_pix(8'h11);
        add_known(8'h00, 64'h0000_0011_1111_0100, 5, 1'b0, 32'd27);
        add_known(8'h22, 64'h0000_FF22_2222_0102, 6, 1'b1, 32'd27);
        // height saturates, then is lowered under the current row
        add_reg(CFG_COLUMN_HEIGHT, 11'd2047);
        add_reg(CFG_TRANSP_EN, 11'd0);
        add_pix(8'hA5);
        add_pix(8'h5A);
        add_pix(8'h00);
        add_pix(8'hFF);
        add_pix(8'h01);
        add_pix(8'h80);
        add_pix(8'h7F);
        add_pix(8'hFE);
        add_reg(CFG_COLUMN_HEIGHT, 11'd4);
        add_pix(8'h3C);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_REG) begin
                drain();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end else begin
                feed_pixel(stim_table[i].pix, stim_table[i].known, stim_table[i].want);
            end
        end

        while (items_sent < 100) random_phase($urandom_range(5, 30));
        tall_column();
        quiet = 1'b1;
        while (items_sent < 410) random_phase($urandom_range(5, 30));

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fails == 0)
            $display("tb_picture_column_post_encoder passed");
        else
            $display("tb_picture_column_post_encoder failed");
        $finish;
    end

    // receiver back-pressure in bursts
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // output beat check against the oldest expected chunk
    always @(posedge aclk) begin
        chunk_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chunks.size() == 0) begin
                $error("unexpected beat: chunk_bytes %h byte_count %0d",
                       m_chunk_bytes, m_byte_count);
                fails++;
            end else begin
                want = pending_chunks.pop_front();
                if (m_chunk_bytes !== want.data) begin
                    $error("chunk_bytes: expected %h, got %h", want.data, m_chunk_bytes);
                    fails++;
                end
                if (m_byte_count !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, m_byte_count);
                    fails++;
                end
                if (m_last_of_run !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_last_of_run);
                    fails++;
                end
                if (m_column_end !== want.col_end) begin
                    $error("column_end: expected %b, got %b", want.col_end, m_column_end);
                    fails++;
                end
                if (m_column_offset !== want.offset) begin
                    $error("column_offset: expected %h, got %h", want.offset,
                           m_column_offset);
                    fails++;
                end
            end
        end
    end

endmodule
